FILE: src/kdb_pkg.sv
// Shared types, constants and helpers for the key debounce / soft-key event block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package kdb_pkg;

  localparam int NUM_HARD_KEYS = 4;
  localparam int NUM_SOFT_KEYS = 6;
  localparam int SEL_W         = 2;
  localparam int SK_W          = 3;
  localparam int EV_W          = 2;
  localparam int CNT_W         = 8;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int QUEUE_DEPTH   = 2;

  // register indexes
  localparam logic [2:0] REG_ACTIVE_LEVELS  = 3'd0;
  localparam logic [2:0] REG_FILTER_TICKS   = 3'd1;
  localparam logic [2:0] REG_COMBO_MASK     = 3'd2;
  localparam logic [2:0] REG_FIRST_KEY_SEL  = 3'd3;
  localparam logic [2:0] REG_SECOND_KEY_SEL = 3'd4;

  // event codes
  localparam logic [EV_W-1:0] EV_PRESS_DOWN = 2'd0;
  localparam logic [EV_W-1:0] EV_HELD       = 2'd1;
  localparam logic [EV_W-1:0] EV_PRESS_UP   = 2'd2;

  // soft key readings
  localparam logic [1:0] RD_RELEASED    = 2'd0;
  localparam logic [1:0] RD_PRESSED     = 2'd1;
  localparam logic [1:0] RD_INTERRUPTED = 2'd2;

  typedef struct packed {
    logic [NUM_HARD_KEYS-1:0]            active_levels;
    logic [CNT_W-1:0]                    filter_ticks;
    logic [NUM_SOFT_KEYS-1:0]            combo_mask;
    logic [NUM_SOFT_KEYS-1:0][SEL_W-1:0] first_key_sel;
    logic [NUM_SOFT_KEYS-1:0][SEL_W-1:0] second_key_sel;
  } kdb_cfg_t;

  // events raised by one tick: which soft keys fire, and with what code
  typedef struct packed {
    logic [NUM_SOFT_KEYS-1:0]           mask;
    logic [NUM_SOFT_KEYS-1:0][EV_W-1:0] code;
  } kdb_evset_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kdb_qstat_t;

  function automatic logic [NUM_HARD_KEYS-1:0] key_bit(input logic [SEL_W-1:0] sel);
    logic [NUM_HARD_KEYS-1:0] v;
    v = '0;
    if (32'(sel) < NUM_HARD_KEYS) begin
      v[sel] = 1'b1;
    end
    return v;
  endfunction

endpackage

FILE: src/kdb_if.sv
// Handshake channel interfaces for scan ticks and soft-key events.
// Depends on kdb_pkg for field widths.
`timescale 1ns / 1ps

interface kdb_in_if import kdb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [NUM_HARD_KEYS-1:0] raw_levels;

  modport source(output valid, output raw_levels, input ready);
  modport sink(input valid, input raw_levels, output ready);
endinterface

interface kdb_out_if import kdb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SK_W-1:0] soft_key;
  logic [EV_W-1:0] event_code;
  logic            last;

  modport source(output valid, output soft_key, output event_code, output last, input ready);
  modport sink(input valid, input soft_key, input event_code, input last, output ready);
endinterface

FILE: src/kdb_cfg.sv
// APB-style configuration registers with their reset values.
// Depends on kdb_pkg.
`timescale 1ns / 1ps

module kdb_cfg import kdb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output kdb_cfg_t          cfg
);

  kdb_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_levels  <= 4'd8;
      cfg_r.filter_ticks   <= 8'd2;
      cfg_r.combo_mask     <= 6'd48;
      cfg_r.first_key_sel  <= 12'd4068;
      cfg_r.second_key_sel <= 12'd2048;
    end else if (wr_en) begin
      case (idx)
        REG_ACTIVE_LEVELS:  cfg_r.active_levels  <= pwdata[NUM_HARD_KEYS-1:0];
        REG_FILTER_TICKS:   cfg_r.filter_ticks   <= pwdata[CNT_W-1:0];
        REG_COMBO_MASK:     cfg_r.combo_mask     <= pwdata[NUM_SOFT_KEYS-1:0];
        REG_FIRST_KEY_SEL:  cfg_r.first_key_sel  <= pwdata[NUM_SOFT_KEYS*SEL_W-1:0];
        REG_SECOND_KEY_SEL: cfg_r.second_key_sel <= pwdata[NUM_SOFT_KEYS*SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_ACTIVE_LEVELS:  prdata = DATA_W'(cfg_r.active_levels);
      REG_FILTER_TICKS:   prdata = DATA_W'(cfg_r.filter_ticks);
      REG_COMBO_MASK:     prdata = DATA_W'(cfg_r.combo_mask);
      REG_FIRST_KEY_SEL:  prdata = DATA_W'(cfg_r.first_key_sel);
      REG_SECOND_KEY_SEL: prdata = DATA_W'(cfg_r.second_key_sel);
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: src/kdb_front.sv
// Front end: debounces the hard keys of each tick and classifies every soft key,
// pushing any non-empty event set into the queue. Depends on kdb_pkg and kdb_if.
`timescale 1ns / 1ps

module kdb_front import kdb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kdb_in_if.sink     in_ch,
  input  kdb_cfg_t   cfg,
  input  kdb_qstat_t qstat,
  output logic       push,
  output kdb_evset_t push_data
);

  logic [NUM_HARD_KEYS-1:0]            deb_r, deb_nxt;
  logic [NUM_HARD_KEYS-1:0][CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_SOFT_KEYS-1:0]            prs_r, prs_nxt;
  logic                                accept;

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [CNT_W-1:0]         inc;
    logic                     pressed;
    logic [NUM_HARD_KEYS-1:0] b1, b2;
    logic [1:0]               rd;
    deb_nxt   = deb_r;
    cnt_nxt   = cnt_r;
    prs_nxt   = prs_r;
    push_data = '0;
    for (int i = 0; i < NUM_HARD_KEYS; i++) begin
      pressed = (in_ch.raw_levels[i] == cfg.active_levels[i]);
      inc     = cnt_r[i] + CNT_W'(1);
      if (pressed != deb_r[i]) begin
        if (inc >= cfg.filter_ticks) begin
          deb_nxt[i] = ~deb_r[i];
          cnt_nxt[i] = '0;
        end else begin
          cnt_nxt[i] = inc;
        end
      end else begin
        cnt_nxt[i] = '0;
      end
    end
    for (int k = 0; k < NUM_SOFT_KEYS; k++) begin
      b1 = key_bit(cfg.first_key_sel[k]);
      b2 = key_bit(cfg.second_key_sel[k]);
      if (!cfg.combo_mask[k]) begin
        if ((deb_nxt & ~b1) != '0) begin
          rd = RD_INTERRUPTED;
        end else begin
          rd = ((deb_nxt & b1) != '0) ? RD_PRESSED : RD_RELEASED;
        end
      end else begin
        if ((deb_nxt & ~(b1 | b2)) != '0 || (deb_nxt & b1) == '0) begin
          rd = RD_INTERRUPTED;
        end else begin
          rd = ((deb_nxt & b2) != '0) ? RD_PRESSED : RD_RELEASED;
        end
      end
      if (!prs_r[k]) begin
        if (rd == RD_PRESSED) begin
          push_data.mask[k] = 1'b1;
          push_data.code[k] = EV_PRESS_DOWN;
          prs_nxt[k]        = 1'b1;
        end
      end else if (rd == RD_PRESSED) begin
        push_data.mask[k] = 1'b1;
        push_data.code[k] = EV_HELD;
      end else begin
        // interrupted keys drop back silently
        if (rd == RD_RELEASED) begin
          push_data.mask[k] = 1'b1;
          push_data.code[k] = EV_PRESS_UP;
        end
        prs_nxt[k] = 1'b0;
      end
    end
  end

  // ticks that raise nothing need no queue slot
  assign push = accept && (push_data.mask != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= '0;
      cnt_r <= '0;
      prs_r <= '0;
    end else if (accept) begin
      deb_r <= deb_nxt;
      cnt_r <= cnt_nxt;
      prs_r <= prs_nxt;
    end
  end

endmodule

FILE: src/kdb_queue.sv
// Short queue of per-tick event sets between front and back end.
// Depends on kdb_pkg.
`timescale 1ns / 1ps

module kdb_queue import kdb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  kdb_evset_t push_data,
  input  logic       pop,
  output kdb_evset_t pop_data,
  output kdb_qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  kdb_evset_t         mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0] count_r;

  assign qstat.full  = (count_r == CNT_W_Q'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign pop_data    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W_Q'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W_Q'(1);
      end
    end
  end

endmodule

FILE: src/kdb_back.sv
// Back end: takes queued event sets and streams one event per cycle while out_ch
// is ready, lowest soft key first, via an output register. Uses kdb_pkg and kdb_if.
`timescale 1ns / 1ps

module kdb_back import kdb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  kdb_evset_t pop_data,
  input  kdb_qstat_t qstat,
  output logic       pop,
  output logic       busy,
  kdb_out_if.source  out_ch
);

  logic                               busy_r, busy_nxt;
  logic [NUM_SOFT_KEYS-1:0]           mask_r, mask_nxt, rem;
  logic [NUM_SOFT_KEYS-1:0][EV_W-1:0] code_r, code_nxt;
  logic                               ov_r, ov_nxt;
  logic [SK_W-1:0]                    sk_r, sk_nxt, sel;
  logic [EV_W-1:0]                    ec_r, ec_nxt;
  logic                               last_r, last_nxt;
  logic                               adv, emit;

  assign out_ch.valid      = ov_r;
  assign out_ch.soft_key   = sk_r;
  assign out_ch.event_code = ec_r;
  assign out_ch.last       = last_r;
  assign busy              = busy_r;

  always_comb begin
    sel = '0;
    for (int k = NUM_SOFT_KEYS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel = SK_W'(k);
      end
    end
    rem      = mask_r & ~(NUM_SOFT_KEYS'(1) << sel);
    adv      = !ov_r || out_ch.ready;
    emit     = adv && busy_r;
    pop      = !qstat.empty && (!busy_r || (emit && rem == '0));

    ov_nxt   = ov_r;
    sk_nxt   = sk_r;
    ec_nxt   = ec_r;
    last_nxt = last_r;
    if (emit) begin
      ov_nxt   = 1'b1;
      sk_nxt   = sel;
      ec_nxt   = code_r[sel];
      last_nxt = (rem == '0);
    end else if (adv) begin
      ov_nxt = 1'b0;
    end

    busy_nxt = busy_r;
    mask_nxt = mask_r;
    code_nxt = code_r;
    if (pop) begin
      busy_nxt = 1'b1;
      mask_nxt = pop_data.mask;
      code_nxt = pop_data.code;
    end else if (emit) begin
      mask_nxt = rem;
      busy_nxt = (rem != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    code_r <= code_nxt;
    sk_r   <= sk_nxt;
    ec_r   <= ec_nxt;
    last_r <= last_nxt;
  end

endmodule

FILE: src/key_debounce_event_fsm.sv
// Key debounce with single and combo soft keys: top level.
// A tick's events pass the queue, the back end's event-set register and the
// output register. Throughput: a tick is taken every cycle while the event
// queue has room; the back end streams one event per cycle while out_ch is ready.
// Reset (synchronous, active low): keys released, counters zero, soft keys idle.
`timescale 1ns / 1ps

module key_debounce_event_fsm import kdb_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  kdb_in_if.sink            in_ch,
  kdb_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  kdb_cfg_t   cfg;
  kdb_qstat_t qstat;
  kdb_evset_t push_data, pop_data;
  logic       push, pop, back_busy;

  kdb_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  kdb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg), .qstat(qstat),
    .push(push), .push_data(push_data)
  );

  kdb_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .qstat(qstat)
  );

  kdb_back u_back (
    .clk(clk), .rst_n(rst_n), .pop_data(pop_data), .qstat(qstat),
    .pop(pop), .busy(back_busy), .out_ch(out_ch)
  );

`ifndef NO_ASSERTIONS
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty at once");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> back_busy)
    else $error("event without last while back end has nothing pending");

  a_next_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
    else $error("tick's events not streamed back to back");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");
`endif

endmodule
